// ===== rtl/core/b2da_pkg.sv =====
// Shared types and constants of the binary-to-decimal ASCII converter.
`default_nettype none

package b2da_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int IN_BITS         = 64;
    localparam int CHAR_WIDTH      = 6;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

    typedef struct packed {
        logic [IN_BITS-1:0] value_bits;
        logic               is_signed;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] character;
        logic                  last;
    } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/b2da_front.sv =====
// Front end: takes the input word, decides the sign and forms the magnitude.
`default_nettype none

module b2da_front #(
    parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
    input  wire b2da_pkg::in_word_t   s_data,
    input  wire logic                 s_valid,
    output logic                      push_valid,
    output logic [VALUE_WIDTH:0]      push_data
);

    logic [VALUE_WIDTH-1:0] value;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;

    always_comb begin
        value = s_data.value_bits[VALUE_WIDTH-1:0];
        neg   = s_data.is_signed & value[VALUE_WIDTH-1];
        // unsigned negate, so the most negative value keeps its full magnitude
        mag   = neg ? (~value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value;
    end

    assign push_valid = s_valid;
    assign push_data  = {neg, mag};

endmodule

`default_nettype wire

// ===== rtl/core/b2da_queue.sv =====
// Two-entry queue between the front end and the digit engine.
`default_nettype none

module b2da_queue #(
    parameter int WIDTH = b2da_pkg::VALUE_WIDTH_DEF + 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int DEPTH = b2da_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop & pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== rtl/core/b2da_back.sv =====
// Digit engine: shift-add-3 conversion, leading zero strip and character output.
`default_nettype none

module b2da_back #(
    parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 pop_valid,
    output logic                      pop,
    input  wire logic [VALUE_WIDTH:0] pop_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output b2da_pkg::out_word_t       m_data
);

    localparam int STEP  = 4;                                   // bits per cycle
    localparam int PW    = ((VALUE_WIDTH + STEP - 1) / STEP) * STEP;
    localparam int NIT   = PW / STEP;
    localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;  // digits of 2^W - 1
    localparam int BW    = 4 * NDIG;
    localparam int IW    = (NIT > 1) ? $clog2(NIT) : 1;
    localparam int RW    = $clog2(NDIG + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [BW-1:0] bcd_reg, bcd_next;
    logic [PW-1:0] bin_reg, bin_next;
    logic [IW-1:0] iter_reg, iter_next;
    logic [RW-1:0] remain_reg, remain_next;
    logic          neg_reg, neg_next;
    logic          m_valid_reg, m_valid_next;
    b2da_pkg::out_word_t m_word_reg, m_word_next;

    logic [BW-1:0] bcd_step;
    logic [PW-1:0] bin_step;
    logic [3:0]    top_digit;
    logic          slot_free;
    logic          load_out;

    assign top_digit = bcd_reg[BW-1 -: 4];
    assign slot_free = !m_valid_reg || m_ready;

    // STEP rounds of adjust-then-shift per cycle
    always_comb begin
        bcd_step = bcd_reg;
        bin_step = bin_reg;
        for (int s = 0; s < STEP; s++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (bcd_step[4*d +: 4] >= 4'd5) begin
                    bcd_step[4*d +: 4] = bcd_step[4*d +: 4] + 4'd3;
                end
            end
            bcd_step = {bcd_step[BW-2:0], bin_step[PW-1]};
            bin_step = {bin_step[PW-2:0], 1'b0};
        end
    end

    always_comb begin
        state_next   = state_reg;
        bcd_next     = bcd_reg;
        bin_next     = bin_reg;
        iter_next    = iter_reg;
        remain_next  = remain_reg;
        neg_next     = neg_reg;
        m_word_next  = m_word_reg;
        pop          = 1'b0;
        load_out     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    pop        = 1'b1;
                    bin_next   = PW'(pop_data[VALUE_WIDTH-1:0]);
                    bcd_next   = '0;
                    neg_next   = pop_data[VALUE_WIDTH];
                    iter_next  = IW'(NIT - 1);
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next = bcd_step;
                bin_next = bin_step;
                if (iter_reg == '0) begin
                    remain_next = RW'(NDIG);
                    state_next  = ST_SKIP;
                end else begin
                    iter_next = iter_reg - IW'(1);
                end
            end
            ST_SKIP: begin
                // drop leading zero digits, keeping at least one
                if (top_digit == 4'd0 && remain_reg != RW'(1)) begin
                    bcd_next    = {bcd_reg[BW-5:0], 4'd0};
                    remain_next = remain_reg - RW'(1);
                end else begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    load_out              = 1'b1;
                    m_word_next.character = b2da_pkg::CHAR_MINUS;
                    m_word_next.last      = 1'b0;
                    state_next            = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    load_out              = 1'b1;
                    m_word_next.character = b2da_pkg::CHAR_ZERO
                                          + {{(b2da_pkg::CHAR_WIDTH-4){1'b0}}, top_digit};
                    m_word_next.last      = (remain_reg == RW'(1));
                    bcd_next              = {bcd_reg[BW-5:0], 4'd0};
                    remain_next           = remain_reg - RW'(1);
                    if (remain_reg == RW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bcd_reg    <= bcd_next;
        bin_reg    <= bin_next;
        iter_reg   <= iter_next;
        remain_reg <= remain_next;
        neg_reg    <= neg_next;
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_word_reg;

    a_emit_has_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT || state_reg == ST_SKIP) |-> (remain_reg != '0))
        else $error("digit engine ran out of digits");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && m_word_next.last) |=> (state_reg == ST_IDLE))
        else $error("last character did not close the number");

    a_sign_only_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SIGN) |-> neg_reg)
        else $error("minus sign on a non-negative value");

endmodule

`default_nettype wire

// ===== rtl/core/binary_to_decimal_ascii.sv =====
// Top level of the binary-to-decimal ASCII converter.
//
// Each input word carries a value and a flag that reads it as two's complement or unsigned;
// the block returns its decimal text one ASCII character per output word, most significant
// first, with a leading '-' for negative signed values and last set on the final digit. The
// front end forms sign and magnitude and parks them in a two-entry queue, so a new word is
// taken while the previous number is still being converted or printed. The digit engine
// converts with shift-add-3 at four bits per cycle, strips leading zeros at one digit per
// cycle and then sends one character per cycle while the output is not stalled. NDIG, the
// digit count of the largest value, is 20 at 64 bits; the engine starts the next number only
// after it has loaded the last character of the current one into its output register.
`default_nettype none

module binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire b2da_pkg::in_word_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output b2da_pkg::out_word_t      m_data
);

    logic                 push_valid;
    logic [VALUE_WIDTH:0] push_data;
    logic                 pop_valid;
    logic                 pop;
    logic [VALUE_WIDTH:0] pop_data;

    b2da_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .s_data     (s_data),
        .s_valid    (s_valid),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    b2da_queue #(
        .WIDTH (VALUE_WIDTH + 1)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (s_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    b2da_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
